// ===== rtl/assert_macros.svh =====
// Shared assertion shorthands for the token lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/wtl_pkg.sv =====
package wtl_pkg;

   localparam int MAX_TOKENS = 3;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_DATA_W = 8;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        overflow;
      logic        last;
   } token_type;

   // Tokens caused by one byte, tok[0] first.
   typedef struct packed {
      logic [1:0]                  count;
      token_type [MAX_TOKENS-1:0]  tok;
   } step_out_type;

endpackage

// ===== rtl/wtl_scan.sv =====
`include "assert_macros.svh"

module wtl_scan
   import wtl_pkg::*;
#(
   parameter int OFFSET_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         high_bytes_blank,
   input  logic [7:0]   text_byte,
   input  logic         text_end,
   input  logic         fire,
   output step_out_type step
);

   localparam logic [2:0] M_BETWEEN = 3'd0;
   localparam logic [2:0] M_SLASH   = 3'd1;
   localparam logic [2:0] M_GT      = 3'd2;
   localparam logic [2:0] M_COMMENT = 3'd3;
   localparam logic [2:0] M_STAR    = 3'd4;
   localparam logic [2:0] M_QUOTE   = 3'd5;
   localparam logic [2:0] M_QSEEN   = 3'd6;
   localparam logic [2:0] M_RUN     = 3'd7;

   localparam logic [2:0] CLS_NUMBER = 3'd0;
   localparam logic [2:0] CLS_SIGNED = 3'd1;
   localparam logic [2:0] CLS_FLOAT  = 3'd2;
   localparam logic [2:0] CLS_NAME   = 3'd3;
   localparam logic [2:0] CLS_STRING = 3'd4;
   localparam logic [2:0] CLS_NONE   = 3'd7;

   localparam logic [3:0] KIND_END      = 4'd0;
   localparam logic [3:0] KIND_COLON    = 4'd1;
   localparam logic [3:0] KIND_DOLLAR   = 4'd2;
   localparam logic [3:0] KIND_AT       = 4'd3;
   localparam logic [3:0] KIND_EQUALS   = 4'd4;
   localparam logic [3:0] KIND_LBRACE   = 4'd5;
   localparam logic [3:0] KIND_RBRACE   = 4'd6;
   localparam logic [3:0] KIND_LBRACKET = 4'd7;
   localparam logic [3:0] KIND_RBRACKET = 4'd8;
   localparam logic [3:0] KIND_PREAMBLE = 4'd9;
   localparam logic [3:0] KIND_RUN_BASE = 4'd10;
   localparam logic [3:0] KIND_STRING   = 4'd14;

   localparam logic [7:0] BLANK_LIMIT = 8'h21;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_GT       = 8'h3E;
   localparam logic [7:0] CH_LT       = 8'h3C;
   localparam logic [7:0] CH_QUOTE    = 8'h27;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_UNDER    = 8'h5F;

   localparam int NUM_CAND = 4;

   function automatic logic is_blank(input logic [7:0] b, input logic hbb);
      return (b < BLANK_LIMIT) || (hbb && b[7]);
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] b);
      logic [3:0] k;
      unique case (b)
         CH_COLON:    k = KIND_COLON;
         CH_DOLLAR:   k = KIND_DOLLAR;
         CH_AT:       k = KIND_AT;
         CH_EQUALS:   k = KIND_EQUALS;
         CH_LBRACE:   k = KIND_LBRACE;
         CH_RBRACE:   k = KIND_RBRACE;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         default:     k = KIND_END;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] promote(input logic [2:0] cls, input logic [7:0] b);
      logic       fresh;
      logic       letter;
      logic [2:0] r;
      fresh  = (cls == CLS_NONE);
      letter = (b == CH_UNDER) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
      priority if (cls == CLS_STRING) begin
         r = CLS_STRING;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         r = fresh ? CLS_NUMBER : cls;
      end else if (b == CH_DOT) begin
         r = (fresh || cls == CLS_NUMBER || cls == CLS_SIGNED) ? CLS_FLOAT : CLS_STRING;
      end else if (letter) begin
         r = (cls == CLS_NAME || fresh || cls == CLS_NUMBER) ? CLS_NAME : CLS_STRING;
      end else begin
         r = CLS_STRING;
      end
      return r;
   endfunction

   logic [2:0]             mode_ff, mode_in;
   logic [2:0]             cls_ff, cls_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   sat_ff, sat_in;

   logic                   at_max;
   logic [OFFSET_BITS-1:0] pos_inc;
   logic                   sat_now;
   logic                   do_start;
   logic                   do_run;
   logic [2:0]             run_cls;
   logic                   blank;
   logic [3:0]             pk;
   logic                   stop;
   logic [2:0]             mode_s;
   logic [2:0]             cls_s;
   logic [OFFSET_BITS-1:0] start_s;

   logic [NUM_CAND-1:0]    cand_v;
   token_type              cand [NUM_CAND];
   logic [2:0]             n_tok;

   assign at_max  = &pos_ff;
   assign pos_inc = at_max ? pos_ff : pos_ff + OFFSET_BITS'(1);
   assign sat_now = sat_ff | at_max;
   assign blank   = is_blank(text_byte, high_bytes_blank);
   assign pk      = punct_kind(text_byte);
   assign stop    = blank || (pk != KIND_END && text_byte != CH_DOLLAR);

   always_comb begin
      mode_s   = mode_ff;
      cls_s    = cls_ff;
      start_s  = start_ff;
      do_start = 1'b0;
      do_run   = 1'b0;
      run_cls  = cls_ff;
      cand_v   = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         cand[i] = '0;
         cand[i].overflow = sat_now;
      end

      unique case (mode_ff)
         M_BETWEEN: do_start = 1'b1;
         M_SLASH: begin
            if (text_byte == CH_STAR) begin
               mode_s = M_COMMENT;
            end else begin
               do_run  = 1'b1;
               run_cls = CLS_STRING;
            end
         end
         M_GT: begin
            if (text_byte == CH_LT) begin
               cand_v[0]      = 1'b1;
               cand[0].kind   = KIND_PREAMBLE;
               cand[0].start  = 16'(start_ff);
               cand[0].length = 16'd2;
               mode_s         = M_BETWEEN;
            end else begin
               do_run  = 1'b1;
               run_cls = CLS_STRING;
            end
         end
         M_COMMENT: begin
            if (text_byte == CH_STAR) mode_s = M_STAR;
         end
         M_STAR: begin
            if (text_byte == CH_SLASH) mode_s = M_BETWEEN;
            else if (text_byte != CH_STAR) mode_s = M_COMMENT;
         end
         M_QUOTE: begin
            if (text_byte == CH_QUOTE) mode_s = M_QSEEN;
         end
         M_QSEEN: begin
            if (text_byte == CH_QUOTE) begin
               mode_s = M_QUOTE;
            end else begin
               cand_v[0]      = 1'b1;
               cand[0].kind   = KIND_STRING;
               cand[0].start  = 16'(start_ff);
               cand[0].length = 16'(pos_ff - start_ff);
               do_start       = 1'b1;
            end
         end
         default: do_run = 1'b1;
      endcase

      // run byte: either closes the run or promotes its class
      if (do_run) begin
         if (stop) begin
            cand_v[0]      = 1'b1;
            cand[0].kind   = KIND_RUN_BASE + {1'b0, run_cls};
            cand[0].start  = 16'(start_ff);
            cand[0].length = 16'(pos_ff - start_ff);
            do_start       = 1'b1;
         end else begin
            mode_s = M_RUN;
            cls_s  = promote(run_cls, text_byte);
         end
      end

      // token start on this byte
      if (do_start) begin
         mode_s = M_BETWEEN;
         cls_s  = CLS_NONE;
         if (!blank) begin
            if (pk != KIND_END) begin
               cand_v[1]      = 1'b1;
               cand[1].kind   = pk;
               cand[1].start  = 16'(pos_ff);
               cand[1].length = 16'd1;
            end else begin
               start_s = pos_ff;
               priority if (text_byte == CH_SLASH) begin
                  mode_s = M_SLASH;
               end else if (text_byte == CH_GT) begin
                  mode_s = M_GT;
               end else if (text_byte == CH_QUOTE) begin
                  mode_s = M_QUOTE;
               end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                  mode_s = M_RUN;
                  cls_s  = CLS_SIGNED;
               end else begin
                  mode_s = M_RUN;
                  cls_s  = promote(CLS_NONE, text_byte);
               end
            end
         end
      end

      // end of text: flush the pending token, then the end token
      if (text_end) begin
         if (mode_s == M_SLASH || mode_s == M_GT || mode_s == M_QUOTE
             || mode_s == M_QSEEN) begin
            cand_v[2]      = 1'b1;
            cand[2].kind   = KIND_STRING;
            cand[2].start  = 16'(start_s);
            cand[2].length = 16'(pos_inc - start_s);
         end else if (mode_s == M_RUN) begin
            cand_v[2]      = 1'b1;
            cand[2].kind   = KIND_RUN_BASE + {1'b0, cls_s};
            cand[2].start  = 16'(start_s);
            cand[2].length = 16'(pos_inc - start_s);
         end
         cand_v[3]      = 1'b1;
         cand[3].kind   = KIND_END;
         cand[3].start  = 16'(pos_inc);
         cand[3].length = 16'd0;
      end
   end

   // pack the candidates in order, at most three; extras are dropped
   always_comb begin
      step  = '0;
      n_tok = 3'd0;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (cand_v[i] && n_tok < 3'(MAX_TOKENS)) begin
            step.tok[n_tok[1:0]] = cand[i];
            n_tok = n_tok + 3'd1;
         end
      end
      for (int i = 0; i < MAX_TOKENS; i++) begin
         step.tok[i].last = (n_tok != 3'd0) && (3'(i) == n_tok - 3'd1);
      end
      step.count = n_tok[1:0];
   end

   always_comb begin
      mode_in  = mode_s;
      cls_in   = cls_s;
      start_in = start_s;
      pos_in   = pos_inc;
      sat_in   = sat_now;
      if (text_end) begin
         mode_in  = M_BETWEEN;
         cls_in   = CLS_NONE;
         start_in = '0;
         pos_in   = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_BETWEEN;
         cls_ff   <= CLS_NONE;
         start_ff <= '0;
         pos_ff   <= '0;
         sat_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         cls_ff   <= cls_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         sat_ff   <= sat_in;
      end
   end

   `ASSERT_NEXT(a_end_clears, clock, reset, fire && text_end, mode_ff == M_BETWEEN && pos_ff == '0 && !sat_ff)
   `ASSERT_IMPLY(a_end_last, clock, reset, fire && text_end, step.count != 2'd0 && step.tok[step.count - 2'd1].kind == KIND_END || step.count == 2'd3)

endmodule

// ===== rtl/wtl_out_buf.sv =====
`include "assert_macros.svh"

module wtl_out_buf
   import wtl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_out_type step,
   input  logic         pop_ready,
   output logic         free,
   output logic         tok_valid,
   output token_type    tok_head
);

   token_type  ent_ff [MAX_TOKENS];
   token_type  ent_in [MAX_TOKENS];
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign tok_valid = (cnt_ff != 2'd0);
   assign tok_head  = ent_ff[0];
   assign pop       = tok_valid && pop_ready;
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop_ready);

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_TOKENS; i++) ent_in[i] = ent_ff[i];
      if (load) begin
         cnt_in = step.count;
         for (int i = 0; i < MAX_TOKENS; i++) ent_in[i] = step.tok[i];
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < MAX_TOKENS - 1; i++) ent_in[i] = ent_ff[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) ent_ff[i] <= ent_in[i];
   end

   `ASSERT_IMPLY(a_load_when_free, clock, reset, load, free)
   `ASSERT_NEXT(a_pop_drains, clock, reset, pop && !load, cnt_ff == $past(cnt_ff) - 2'd1)

endmodule

// ===== rtl/wsi_token_lexer_core.sv =====
// Token lexer: takes a text one byte per beat and emits its tokens.
//  req_*  : one text byte per beat, req_tlast on the final byte of a text.
//  rsp_*  : one token per beat (kind, start offset, length, overflow flag);
//           rsp_tlast marks the last token caused by a given byte.
//  csr_*  : sole register high_bytes_blank; user writes it while idle, unchecked.
// Path: an accepted byte is registered in the input register and scanned
// combinationally from there; its tokens are registered in the result buffer,
// which drives rsp_* directly.
// Throughput: one byte per cycle while no token-causing byte waits for the
// buffer. Bytes causing no token (most of them) never wait on the result side;
// a byte causing k tokens occupies the three-entry result buffer for k output
// beats, the input register holding the next token-causing byte until the buffer frees.
// Reset: scanner between tokens, offsets zero, result buffer empty,
// high_bytes_blank set to 1. No clearing pass.
// Receiver stall: tokens wait in the result buffer; the input register still
// takes a byte, and bytes that cause no token keep flowing through.
module wsi_token_lexer_core
   import wtl_pkg::*;
#(
   parameter int OFFSET_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // text byte channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // text_end
   // token channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] token_kind, [19:4] token_start,
                                              // [35:20] token_length,
                                              // [36] offset_overflow, [39:37] zero
   output logic                  rsp_tlast,   // run_last
   // configuration
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data  // high_bytes_blank
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       hbb_ff;

   step_out_type step;
   token_type    head;
   logic         buf_free;
   logic         step_fire;
   logic         buf_load;

   // a byte with no tokens never needs the buffer
   assign step_fire   = in_valid_ff && (step.count == 2'd0 || buf_free);
   assign buf_load    = step_fire && (step.count != 2'd0);
   assign req_tready  = !in_valid_ff || step_fire;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hbb_ff      <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) hbb_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   wtl_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .high_bytes_blank (hbb_ff),
      .text_byte        (in_byte_ff),
      .text_end         (in_end_ff),
      .fire             (step_fire),
      .step             (step)
   );

   wtl_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (buf_load),
      .step      (step),
      .pop_ready (rsp_tready),
      .free      (buf_free),
      .tok_valid (rsp_tvalid),
      .tok_head  (head)
   );

   assign rsp_tdata = {3'b000, head.overflow, head.length, head.start, head.kind};
   assign rsp_tlast = head.last;

endmodule
